// ===== rtl/rtwe_pkg.sv =====
// shared types and constants of the route table with expiry
package rtwe_pkg;

    // default table depth
    localparam int DefEntries = 128;

    // fixed field widths
    localparam int CountW = 8;
    localparam int ExpW   = 23;

    // milliseconds per second, for the expiry limit
    localparam logic [31:0] MsPerSecond = 32'd1000;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_SWEEP  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [7:0]         dest;
        logic [7:0]         via;
        logic [7:0]         hops;
        logic signed [15:0] quality;
        logic [31:0]        stamp;
        logic               active;
    } entry_t;

    // compare unit flags for the entry under test
    typedef struct packed {
        logic dest_eq;
        logic live;
        logic aged;
    } match_t;

    // one result item
    typedef struct packed {
        logic [7:0]        route_via;
        logic              hit;
        entry_t            ent;
        logic [CountW-1:0] table_count;
        logic              dropped;
    } result_t;

endpackage

// ===== rtl/rtwe_ram.sv =====
// generic simple dual port ram with registered read
module rtwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rtwe_match.sv =====
// compare unit: destination match and age test of one entry
module rtwe_match import rtwe_pkg::*; (
    input  entry_t      ent,
    input  logic [7:0]  dest,
    input  logic [31:0] now,
    input  logic [31:0] limit,
    output match_t      m
);

    logic [31:0] age;

    // age wraps modulo 2^32 and compares unsigned
    assign age       = now - ent.stamp;
    assign m.dest_eq = (ent.dest == dest);
    assign m.live    = (ent.dest == dest) && ent.active;
    assign m.aged    = (age > limit);

endmodule

// ===== rtl/rtwe_seq.sv =====
// sequencer: scans the table one entry a cycle and builds the result
module rtwe_seq import rtwe_pkg::*; #(
    parameter int ENTRIES = DefEntries,
    localparam int AW = $clog2(ENTRIES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [7:0]        dest_node,
    input  logic [7:0]        via_node,
    input  logic [7:0]        hops,
    input  logic signed [15:0] quality,
    input  logic [31:0]       now_ms,
    input  logic [6:0]        entry_index,
    input  logic [ExpW-1:0]   expiry_seconds,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output entry_t            ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  entry_t            ram_rdata,
    output logic              out_valid,
    input  logic              out_stall,
    output result_t           result
);

    localparam logic [CountW-1:0] EntriesC = CountW'(ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_RDATA,
        ST_FINISH
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [7:0]         dest_reg, dest_next;
    logic [7:0]         via_reg, via_next;
    logic [7:0]         hops_reg, hops_next;
    logic signed [15:0] quality_reg, quality_next;
    logic [31:0]        now_reg, now_next;
    logic [6:0]         idx_reg, idx_next;
    logic [31:0]        limit_reg, limit_next;
    logic [CountW-1:0]  count_reg, count_next;
    logic [CountW-1:0]  scan_idx_reg, scan_idx_next;
    logic [CountW-1:0]  chk_idx_reg, chk_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               found_reg, found_next;
    logic [CountW-1:0]  slot_reg, slot_next;
    entry_t             ent_reg, ent_next;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;

    match_t             m;
    logic               slot_free;
    logic               stop;
    logic               issue;
    logic [CountW-1:0]  idx_ext;
    entry_t             aged_ent;
    entry_t             new_ent;

    // shared compare unit on the ram read data
    rtwe_match u_match (
        .ent   (ram_rdata),
        .dest  (dest_reg),
        .now   (now_reg),
        .limit (limit_reg),
        .m     (m)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign idx_ext   = {1'b0, idx_reg};

    // entry images for the two kinds of write
    always_comb
    begin
        aged_ent        = ram_rdata;
        aged_ent.active = 1'b0;
        new_ent.dest    = dest_reg;
        new_ent.via     = via_reg;
        new_ent.hops    = hops_reg;
        new_ent.quality = quality_reg;
        new_ent.stamp   = now_reg;
        new_ent.active  = 1'b1;
    end

    // scan condition of the current check
    assign stop = chk_valid_reg &&
                  (((cmd_reg == CMD_INSERT) && m.dest_eq) ||
                   ((cmd_reg == CMD_LOOKUP) && m.live));
    assign issue = !stop && (scan_idx_reg < count_reg);

    // next state and ram control
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        dest_next      = dest_reg;
        via_next       = via_reg;
        hops_next      = hops_reg;
        quality_next   = quality_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        ent_next       = ent_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = chk_idx_reg[AW-1:0];
        ram_wdata      = aged_ent;
        ram_raddr      = scan_idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next       = cmd_t'(cmd);
                    dest_next      = dest_node;
                    via_next       = via_node;
                    hops_next      = hops;
                    quality_next   = quality;
                    now_next       = now_ms;
                    idx_next       = entry_index;
                    limit_next     = {{(32 - ExpW){1'b0}}, expiry_seconds} * MsPerSecond;
                    scan_idx_next  = '0;
                    chk_valid_next = 1'b0;
                    found_next     = 1'b0;
                    ent_next       = '0;
                    state_next     = (cmd_t'(cmd) == CMD_READ) ? ST_READ : ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // expired entries lose their active mark
                if (chk_valid_reg && (cmd_reg == CMD_SWEEP) && m.aged)
                begin
                    ram_we = 1'b1;
                end
                chk_valid_next = issue;
                if (issue)
                begin
                    scan_idx_next = CountW'(scan_idx_reg + 1'b1);
                    chk_idx_next  = scan_idx_reg;
                end
                if (stop)
                begin
                    found_next = 1'b1;
                    slot_next  = chk_idx_reg;
                    ent_next   = ram_rdata;
                    state_next = ST_FINISH;
                end
                else if (!issue && !chk_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_READ:
            begin
                ram_raddr  = idx_ext[AW-1:0];
                state_next = ST_RDATA;
            end

            ST_RDATA:
            begin
                ent_next   = ram_rdata;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (slot_free)
                begin
                    res_next       = '0;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    unique case (cmd_reg)
                        CMD_INSERT:
                        begin
                            ram_wdata = new_ent;
                            if (found_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = slot_reg[AW-1:0];
                            end
                            else if (count_reg < EntriesC)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                count_next = CountW'(count_reg + 1'b1);
                            end
                            else
                            begin
                                res_next.dropped = 1'b1;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            res_next.hit       = found_reg;
                            res_next.route_via = found_reg ? ent_reg.via : 8'd0;
                        end
                        CMD_SWEEP:
                        begin
                            res_next.hit = 1'b0;
                        end
                        CMD_READ:
                        begin
                            if (idx_ext < count_reg)
                            begin
                                res_next.hit       = 1'b1;
                                res_next.route_via = ent_reg.via;
                                res_next.ent       = ent_reg;
                            end
                        end
                        default:
                        begin
                            res_next.hit = 1'b0;
                        end
                    endcase
                    res_next.table_count = count_next;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_INSERT;
            dest_reg      <= '0;
            via_reg       <= '0;
            hops_reg      <= '0;
            quality_reg   <= '0;
            now_reg       <= '0;
            idx_reg       <= '0;
            limit_reg     <= '0;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            chk_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            ent_reg       <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            dest_reg      <= dest_next;
            via_reg       <= via_next;
            hops_reg      <= hops_next;
            quality_reg   <= quality_next;
            now_reg       <= now_next;
            idx_reg       <= idx_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            chk_idx_reg   <= chk_idx_next;
            chk_valid_reg <= chk_valid_next;
            found_reg     <= found_next;
            slot_reg      <= slot_next;
            ent_reg       <= ent_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

`ifndef SYNTHESIS
    // table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= EntriesC)
        else $error("entry count beyond table depth");

    // count only ever grows by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == CountW'($past(count_reg) + 1'b1)))
        else $error("entry count changed by other than one");

    // writes during the scan belong to a sweep only
    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ST_SCAN)) |-> (cmd_reg == CMD_SWEEP))
        else $error("table write during scan outside a sweep");

    // a new result comes only out of the finish step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && out_stall)) |->
            $past(state_reg == ST_FINISH))
        else $error("result shown without a finished command");
`endif

endmodule

// ===== rtl/route_table_with_expiry_top.sv =====
// Route table with expiry: one command item in, one result item out, one item in work.
// Insert, lookup and sweep scan the n entries in use, one ram read a cycle through the
// shared compare unit; the scan ends early when insert or lookup matches. Read of one entry
// goes through the read, read-data and finish steps.
// Next item accepted in the same cycle as the result shows; a stalled result delays the one after.
// Reset: entry count 0, expiry 60 s; the ram is not cleared, only entries below count are read.
module route_table_with_expiry_top import rtwe_pkg::*; #(
    parameter int ENTRIES = DefEntries
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [7:0]         dest_node,
    input  logic [7:0]         via_node,
    input  logic [7:0]         hops,
    input  logic signed [15:0] quality,
    input  logic [31:0]        now_ms,
    input  logic [6:0]         entry_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         next_hop_result,
    output logic               hit,
    output logic [7:0]         entry_dest,
    output logic [7:0]         entry_hops,
    output logic signed [15:0] entry_quality,
    output logic [31:0]        entry_stamp_ms,
    output logic               entry_active,
    output logic [CountW-1:0]  table_count,
    output logic               dropped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ExpW-1:0]    cfg_data
);

    localparam int AW = $clog2(ENTRIES);

    logic [ExpW-1:0] expiry_reg;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    entry_t          ram_wdata;
    entry_t          ram_rdata;
    result_t         result;

    // expiry register, written through the config channel
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expiry_reg <= ExpW'(60);
        end
        else if (cfg_valid && cfg_ready)
        begin
            expiry_reg <= cfg_data;
        end
    end

    // entry storage
    rtwe_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // command sequencer
    rtwe_seq #(
        .ENTRIES (ENTRIES)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .dest_node      (dest_node),
        .via_node       (via_node),
        .hops           (hops),
        .quality        (quality),
        .now_ms         (now_ms),
        .entry_index    (entry_index),
        .expiry_seconds (expiry_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result)
    );

    // result fields onto their ports
    assign next_hop_result = result.route_via;
    assign hit             = result.hit;
    assign entry_dest      = result.ent.dest;
    assign entry_hops      = result.ent.hops;
    assign entry_quality   = result.ent.quality;
    assign entry_stamp_ms  = result.ent.stamp;
    assign entry_active    = result.ent.active;
    assign table_count     = result.table_count;
    assign dropped         = result.dropped;

endmodule

// ===== tb/route_table_with_expiry_top_tb.sv =====
// testbench of the route table with expiry: directed and random commands checked per item
module route_table_with_expiry_top_tb;
    import rtwe_pkg::*;

    localparam int TableDepth = DefEntries;
    localparam int CycleLimit = 1500000;
    localparam int DrainCycles = TableDepth + 40;

    // expected contents of one result item
    typedef struct packed {
        logic [7:0]         route_via;
        logic               hit;
        logic [7:0]         dest;
        logic [7:0]         hops;
        logic signed [15:0] quality;
        logic [31:0]        stamp;
        logic               active;
        logic [CountW-1:0]  count;
        logic               dropped;
    } route_reply_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = 2'd0;
    logic [7:0]         dest_node = 8'd0;
    logic [7:0]         via_node = 8'd0;
    logic [7:0]         hops = 8'd0;
    logic signed [15:0] quality = 16'sd0;
    logic [31:0]        now_ms = 32'd0;
    logic [6:0]         entry_index = 7'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         next_hop_result;
    logic               hit;
    logic [7:0]         entry_dest;
    logic [7:0]         entry_hops;
    logic signed [15:0] entry_quality;
    logic [31:0]        entry_stamp_ms;
    logic               entry_active;
    logic [CountW-1:0]  table_count;
    logic               dropped;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ExpW-1:0]    cfg_data = '0;

    // shadow copy of the table and its expiry setting
    entry_t          route_mem [0:TableDepth-1];
    int              routes_used = 0;
    logic [ExpW-1:0] expiry_s = 23'd60;
    logic [31:0]     clock_ms = 32'd0;

    route_reply_t replies_due [$];
    int           mismatches = 0;
    int           cycles = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;

    route_table_with_expiry_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .dest_node       (dest_node),
        .via_node        (via_node),
        .hops            (hops),
        .quality         (quality),
        .now_ms          (now_ms),
        .entry_index     (entry_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_hop_result (next_hop_result),
        .hit             (hit),
        .entry_dest      (entry_dest),
        .entry_hops      (entry_hops),
        .entry_quality   (entry_quality),
        .entry_stamp_ms  (entry_stamp_ms),
        .entry_active    (entry_active),
        .table_count     (table_count),
        .dropped         (dropped),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // position of the first entry with this destination, -1 when absent
    function automatic int route_slot(input logic [7:0] dest);
        int i;
        int slot;
        slot = -1;
        for (i = 0; i < routes_used && slot < 0; i++)
            if (route_mem[i].dest == dest)
                slot = i;
        return slot;
    endfunction

    // apply one command to the shadow table and return the expected result
    function automatic route_reply_t route_predict(input cmd_t op, input logic [7:0] dest,
        input logic [7:0] via, input logic [7:0] hp, input logic signed [15:0] q,
        input logic [31:0] now, input logic [6:0] idx);
        route_reply_t r;
        int           i;
        int           slot;
        logic [31:0]  age_limit;
        r = '0;
        age_limit = 32'(expiry_s) * MsPerSecond;
        case (op)
            CMD_INSERT:
            begin
                slot = route_slot(dest);
                if (slot < 0)
                begin
                    if (routes_used < TableDepth)
                    begin
                        slot = routes_used;
                        routes_used++;
                    end
                    else
                        r.dropped = 1'b1;
                end
                if (slot >= 0)
                    route_mem[slot] = '{dest: dest, via: via, hops: hp, quality: q,
                                        stamp: now, active: 1'b1};
            end
            CMD_LOOKUP:
            begin
                for (i = 0; i < routes_used && !r.hit; i++)
                    if (route_mem[i].dest == dest && route_mem[i].active)
                    begin
                        r.route_via = route_mem[i].via;
                        r.hit = 1'b1;
                    end
            end
            CMD_SWEEP:
            begin
                // age wraps modulo 2^32 and compares unsigned
                for (i = 0; i < routes_used; i++)
                    if (32'(now - route_mem[i].stamp) > age_limit)
                        route_mem[i].active = 1'b0;
            end
            default:
            begin
                if (int'(idx) < routes_used)
                begin
                    r.route_via = route_mem[idx].via;
                    r.hit = 1'b1;
                    r.dest = route_mem[idx].dest;
                    r.hops = route_mem[idx].hops;
                    r.quality = route_mem[idx].quality;
                    r.stamp = route_mem[idx].stamp;
                    r.active = route_mem[idx].active;
                end
            end
        endcase
        r.count = CountW'(routes_used);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: check each accepted item, then stall at random
    always @(posedge clk)
    begin
        route_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result item with nothing expected");
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                check_field("next_hop_result", 32'(want.route_via), 32'(next_hop_result));
                check_field("hit", 32'(want.hit), 32'(hit));
                check_field("entry_dest", 32'(want.dest), 32'(entry_dest));
                check_field("entry_hops", 32'(want.hops), 32'(entry_hops));
                check_field("entry_quality", 32'(want.quality), 32'(entry_quality));
                check_field("entry_stamp_ms", want.stamp, entry_stamp_ms);
                check_field("entry_active", 32'(want.active), 32'(entry_active));
                check_field("table_count", 32'(want.count), 32'(table_count));
                check_field("dropped", 32'(want.dropped), 32'(dropped));
            end
        end
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // present one command item and predict its result once accepted
    task automatic send_route_cmd(input cmd_t op, input logic [7:0] dest,
        input logic [7:0] via, input logic [7:0] hp, input logic signed [15:0] q,
        input logic [31:0] now, input logic [6:0] idx);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        dest_node <= dest;
        via_node <= via;
        hops <= hp;
        quality <= q;
        now_ms <= now;
        entry_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        replies_due.push_back(route_predict(op, dest, via, hp, q, now, idx));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // expiry register write, only with the block idle
    task automatic write_expiry(input logic [ExpW-1:0] secs);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= secs;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        expiry_s = secs;
    endtask

    // empty table, field extremes, update, wrapped age, inactive match
    task automatic test_basic_routes();
        send_route_cmd(CMD_LOOKUP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd0, 7'd0);
        send_route_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd0, 7'd0);
        send_route_cmd(CMD_SWEEP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd0, 7'd0);
        send_route_cmd(CMD_INSERT, 8'h00, 8'h00, 8'h00, 16'sh8000, 32'd0, 7'd0);
        // hit with next hop zero
        send_route_cmd(CMD_LOOKUP, 8'h00, 8'hFF, 8'hFF, 16'sd0, 32'd0, 7'd0);
        send_route_cmd(CMD_INSERT, 8'hFF, 8'hFF, 8'hFF, 16'sd32767, 32'hFFFF_FFFF, 7'd0);
        send_route_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd0, 7'd1);
        send_route_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd0, 7'd2);
        send_route_cmd(CMD_INSERT, 8'h00, 8'h33, 8'h07, -16'sd1, 32'd100, 7'd0);
        // age exactly at the limit stays, wrapped age beyond it expires
        send_route_cmd(CMD_SWEEP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd60100, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'hFF, 8'h00, 8'h00, 16'sd0, 32'd60100, 7'd0);
        send_route_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd60100, 7'd1);
        send_route_cmd(CMD_INSERT, 8'hFF, 8'h11, 8'h02, 16'sd5, 32'd60100, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'hFF, 8'h00, 8'h00, 16'sd0, 32'd60100, 7'd0);
        send_route_cmd(CMD_SWEEP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd60101, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd60101, 7'd0);
    endtask

    // zero expiry and the largest setting whose limit wraps
    task automatic test_expiry_limits();
        write_expiry(23'd0);
        send_route_cmd(CMD_INSERT, 8'h5A, 8'h21, 8'h03, 16'sd77, 32'd1000, 7'd0);
        send_route_cmd(CMD_SWEEP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd1000, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'h5A, 8'h00, 8'h00, 16'sd0, 32'd1000, 7'd0);
        send_route_cmd(CMD_SWEEP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd1001, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'h5A, 8'h00, 8'h00, 16'sd0, 32'd1001, 7'd0);
        write_expiry(23'h7F_FFFF);
        send_route_cmd(CMD_INSERT, 8'h5A, 8'h22, 8'h04, -16'sd77, 32'd0, 7'd0);
        send_route_cmd(CMD_SWEEP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd4093639704, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'h5A, 8'h00, 8'h00, 16'sd0, 32'd4093639704, 7'd0);
        send_route_cmd(CMD_SWEEP, 8'h00, 8'h00, 8'h00, 16'sd0, 32'd4093639705, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'h5A, 8'h00, 8'h00, 16'sd0, 32'd4093639705, 7'd0);
    endtask

    // fill every free slot, then a new destination is refused
    task automatic test_table_full();
        int d;
        int spare;
        spare = -1;
        for (d = 0; d < 256; d++)
        begin
            if (route_slot(8'(d)) < 0)
            begin
                if (routes_used < TableDepth)
                begin
                    clock_ms += $urandom_range(0, 50);
                    send_route_cmd(CMD_INSERT, 8'(d), 8'($urandom), 8'($urandom),
                                   16'($urandom), clock_ms, 7'd0);
                end
                else if (spare < 0)
                    spare = d;
            end
        end
        send_route_cmd(CMD_INSERT, 8'(spare), 8'h44, 8'h01, 16'sd9, clock_ms, 7'd0);
        send_route_cmd(CMD_INSERT, route_mem[5].dest, 8'h45, 8'h02, -16'sd9, clock_ms, 7'd0);
        send_route_cmd(CMD_LOOKUP, 8'(spare), 8'h00, 8'h00, 16'sd0, clock_ms, 7'd0);
        send_route_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 16'sd0, clock_ms, 7'd127);
        send_route_cmd(CMD_READ, 8'h00, 8'h00, 8'h00, 16'sd0, clock_ms, 7'd5);
    endtask

    // random commands, mostly on known destinations, time moving forward but for occasional jumps
    task automatic run_random_traffic(input int n_items, input int unsigned step_ms);
        int          k;
        int          roll;
        cmd_t        op;
        logic [7:0]  dest;
        logic [6:0]  idx;
        for (k = 0; k < n_items; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 35)
                op = CMD_INSERT;
            else if (roll < 65)
                op = CMD_LOOKUP;
            else if (roll < 75)
                op = CMD_SWEEP;
            else
                op = CMD_READ;
            // occasional jump anywhere on the time line
            if ($urandom_range(0, 19) == 0)
                clock_ms = $urandom;
            else
                clock_ms += $urandom_range(0, step_ms);
            if (routes_used > 0 && $urandom_range(0, 9) < 7)
                dest = route_mem[$urandom_range(0, routes_used - 1)].dest;
            else
                dest = 8'($urandom);
            if (routes_used > 0 && $urandom_range(0, 9) < 8)
                idx = 7'($urandom_range(0, routes_used - 1));
            else
                idx = 7'($urandom);
            send_route_cmd(op, dest, 8'($urandom), 8'($urandom), 16'($urandom),
                           clock_ms, idx);
        end
    endtask

    // test sequence
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 38;
        rx_idle_pct = 73;
        test_basic_routes();
        test_expiry_limits();
        write_expiry(23'd3);
        run_random_traffic(350, 2500);
        test_table_full();

        tx_idle_pct = 73;
        rx_idle_pct = 38;
        write_expiry(23'd4294967);
        run_random_traffic(350, 400000);
        write_expiry(23'd0);
        run_random_traffic(250, 2);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_expiry(23'd1);
        run_random_traffic(450, 800);
        write_expiry(23'd60);
        run_random_traffic(400, 20000);

        drain_results();
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
